// ----- src/ire_pkg.sv -----
// Shared types and constants for the ICCID response extractor.
package ire_pkg;

    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 5;
    localparam int HALF_W     = 48;
    localparam int NIB_W      = 4;
    localparam int MARKER_LEN = 7;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 5'd18;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 5'd24;

    // result status codes
    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_MARKER = 2'd1;
    localparam logic [1:0] STATUS_BARE   = 2'd2;

    // marker field parser phase
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_HEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              final_req;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  id_length;
        logic [HALF_W-1:0] id_upper;
        logic [HALF_W-1:0] id_lower;
    } out_t;

    // classified byte, as queued between front and back
    typedef struct packed {
        logic                  final_req;
        logic                  is_nul;
        logic                  is_dec;
        logic                  is_hex;
        logic [NIB_W-1:0]      hex_val;
        logic                  is_space;
        logic                  is_alnum;
        logic [MARKER_LEN-1:0] marker_hit;
    } cls_t;

endpackage

// ----- src/ire_front.sv -----
// Front end: classifies each response byte and queues it for the parser.
module ire_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ire_pkg::in_t  in_data,
    output logic          q_valid,
    input  logic          q_pop,
    output ire_pkg::cls_t q_item
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // "+ICCID:"
    localparam logic [ire_pkg::CHAR_W-1:0] MARKER_TEXT [ire_pkg::MARKER_LEN] =
        '{8'h2B, 8'h49, 8'h43, 8'h43, 8'h49, 8'h44, 8'h3A};

    function automatic ire_pkg::cls_t classify(input logic [ire_pkg::CHAR_W-1:0] c,
                                               input logic fin);
        ire_pkg::cls_t r;
        logic          dec;
        logic          up;
        logic          lo;
        logic          hex_af;
        r        = '0;
        dec      = (c >= 8'h30) && (c <= 8'h39);
        up       = (c >= 8'h41) && (c <= 8'h5A);
        lo       = (c >= 8'h61) && (c <= 8'h7A);
        hex_af   = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
        r.final_req = fin;
        r.is_nul    = (c == 8'h00);
        r.is_dec    = dec;
        r.is_hex    = dec || hex_af;
        // low nibble is the digit; letters A..F / a..f have low nibble 1..6
        r.hex_val   = dec ? c[3:0] : (c[3:0] + 4'd9);
        r.is_space  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
        r.is_alnum  = dec || up || lo;
        for (int k = 0; k < ire_pkg::MARKER_LEN; k++)
            r.marker_hit[k] = (c == MARKER_TEXT[k]);
        return r;
    endfunction

    ire_pkg::cls_t       q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= classify(in_data.char_in, in_data.final_req);
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

// ----- src/ire_back.sv -----
// Back end: marker field parser, bare digit run tracker and result register.
module ire_back
#(
    parameter int MAX_ID_CHARS = 24
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  ire_pkg::cls_t                    q_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ire_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [ire_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ire_pkg::LEN_W-1:0]        cfg_data
);

    localparam int CNT_W  = $clog2(MAX_ID_CHARS + 2);
    localparam int IDX_W  = $clog2(MAX_ID_CHARS);
    localparam int SAT    = MAX_ID_CHARS + 1;
    localparam int FLAT_W = 2 * ire_pkg::HALF_W;
    localparam int CMP_W  = ire_pkg::LEN_W + 1;
    localparam int POS_W  = $clog2(ire_pkg::MARKER_LEN);

    typedef logic [MAX_ID_CHARS-1:0][ire_pkg::NIB_W-1:0] chars_t;

    function automatic logic len_ok(input logic [CNT_W-1:0] n,
                                    input logic [CMP_W-1:0] lo,
                                    input logic [CMP_W-1:0] hi);
        return (CMP_W'(n) >= lo) && (CMP_W'(n) <= hi);
    endfunction

    // first character lands in the top nibble; characters past n read as zero
    function automatic logic [FLAT_W-1:0] pack_id(input chars_t chars,
                                                  input logic [CNT_W-1:0] n);
        logic [FLAT_W-1:0] flat;
        flat = '0;
        for (int i = 0; i < MAX_ID_CHARS; i++)
            if (CNT_W'(i) < n)
                flat[FLAT_W-1-ire_pkg::NIB_W*i -: ire_pkg::NIB_W] = chars[i];
        return flat;
    endfunction

    logic [ire_pkg::LEN_W-1:0] min_len_reg;
    logic [ire_pkg::LEN_W-1:0] max_len_reg;
    ire_pkg::phase_t           phase_reg,      phase_next;
    logic [POS_W-1:0]          pos_reg,        pos_next;
    logic [CNT_W-1:0]          mk_count_reg,   mk_count_next;
    chars_t                    mk_chars_reg,   mk_chars_next;
    logic                      mk_valid_reg,   mk_valid_next;
    logic [CNT_W-1:0]          dg_count_reg,   dg_count_next;
    chars_t                    dg_chars_reg,   dg_chars_next;
    logic                      bare_valid_reg, bare_valid_next;
    logic [CNT_W-1:0]          bare_count_reg, bare_count_next;
    chars_t                    bare_chars_reg, bare_chars_next;
    logic                      ended_reg,      ended_next;
    logic                      out_valid_reg,  out_valid_next;
    ire_pkg::out_t             out_reg,        out_next;

    logic [CMP_W-1:0]          lo_lim;
    logic [CMP_W-1:0]          hi_lim;
    logic [FLAT_W-1:0]         flat;
    logic                      pop;

    // effective bounds; max_length clamps to the storage depth
    assign lo_lim = CMP_W'(min_len_reg);
    assign hi_lim = (CMP_W'(max_len_reg) > CMP_W'(MAX_ID_CHARS)) ?
                    CMP_W'(MAX_ID_CHARS) : CMP_W'(max_len_reg);

    // a final beat needs the result slot free or emptying
    assign pop       = q_valid && (!q_item.final_req || !out_valid_reg || out_ready);
    assign q_pop     = pop;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // per-byte update, then string end, then result and clear
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        mk_count_next   = mk_count_reg;
        mk_chars_next   = mk_chars_reg;
        mk_valid_next   = mk_valid_reg;
        dg_count_next   = dg_count_reg;
        dg_chars_next   = dg_chars_reg;
        bare_valid_next = bare_valid_reg;
        bare_count_next = bare_count_reg;
        bare_chars_next = bare_chars_reg;
        ended_next      = ended_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        flat            = '0;

        if (pop)
        begin
            // ordinary byte
            if (!ended_reg && !q_item.is_nul)
            begin
                unique case (phase_reg)
                    ire_pkg::PH_SEARCH:
                    begin
                        if (q_item.marker_hit[pos_reg])
                        begin
                            if (pos_reg == POS_W'(ire_pkg::MARKER_LEN - 1))
                            begin
                                pos_next   = '0;
                                phase_next = ire_pkg::PH_SKIP;
                            end
                            else
                            begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                        else
                        begin
                            // a '+' restarts the match at once
                            pos_next = POS_W'(q_item.marker_hit[0]);
                        end
                    end
                    ire_pkg::PH_SKIP, ire_pkg::PH_HEX:
                    begin
                        if (phase_reg == ire_pkg::PH_HEX || !q_item.is_space)
                        begin
                            phase_next = ire_pkg::PH_HEX;
                            if (q_item.is_hex)
                            begin
                                if (mk_count_reg < CNT_W'(MAX_ID_CHARS))
                                    mk_chars_next[mk_count_reg[IDX_W-1:0]] = q_item.hex_val;
                                if (mk_count_reg <= CNT_W'(MAX_ID_CHARS))
                                    mk_count_next = mk_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                mk_valid_next = len_ok(mk_count_reg, lo_lim, hi_lim) &&
                                                !q_item.is_alnum;
                                phase_next    = ire_pkg::PH_DONE;
                            end
                        end
                    end
                    ire_pkg::PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                // decimal run tracking
                if (q_item.is_dec)
                begin
                    if (dg_count_reg < CNT_W'(MAX_ID_CHARS))
                        dg_chars_next[dg_count_reg[IDX_W-1:0]] = q_item.hex_val;
                    if (dg_count_reg <= CNT_W'(MAX_ID_CHARS))
                        dg_count_next = dg_count_reg + CNT_W'(1);
                end
                else
                begin
                    if (dg_count_reg != '0 && !bare_valid_reg &&
                        len_ok(dg_count_reg, lo_lim, hi_lim))
                    begin
                        bare_chars_next = dg_chars_reg;
                        bare_count_next = dg_count_reg;
                        bare_valid_next = 1'b1;
                    end
                    dg_count_next = '0;
                end
            end

            // end of string: zero byte or last byte; open runs close
            if (!ended_reg && (q_item.is_nul || q_item.final_req))
            begin
                if (phase_next == ire_pkg::PH_SKIP || phase_next == ire_pkg::PH_HEX)
                begin
                    mk_valid_next = len_ok(mk_count_next, lo_lim, hi_lim);
                    phase_next    = ire_pkg::PH_DONE;
                end
                if (dg_count_next != '0 && !bare_valid_next &&
                    len_ok(dg_count_next, lo_lim, hi_lim))
                begin
                    bare_chars_next = dg_chars_next;
                    bare_count_next = dg_count_next;
                    bare_valid_next = 1'b1;
                end
                dg_count_next = '0;
                ended_next    = 1'b1;
            end

            // result beat and response clear
            if (q_item.final_req)
            begin
                out_valid_next = 1'b1;
                if (mk_valid_next)
                begin
                    flat               = pack_id(mk_chars_next, mk_count_next);
                    out_next.status    = ire_pkg::STATUS_MARKER;
                    out_next.id_length = ire_pkg::LEN_W'(mk_count_next);
                end
                else if (bare_valid_next)
                begin
                    flat               = pack_id(bare_chars_next, bare_count_next);
                    out_next.status    = ire_pkg::STATUS_BARE;
                    out_next.id_length = ire_pkg::LEN_W'(bare_count_next);
                end
                else
                begin
                    out_next.status    = ire_pkg::STATUS_NONE;
                    out_next.id_length = '0;
                end
                out_next.id_upper = flat[FLAT_W-1 -: ire_pkg::HALF_W];
                out_next.id_lower = flat[ire_pkg::HALF_W-1:0];

                phase_next      = ire_pkg::PH_SEARCH;
                pos_next        = '0;
                mk_count_next   = '0;
                mk_valid_next   = 1'b0;
                dg_count_next   = '0;
                bare_valid_next = 1'b0;
                bare_count_next = '0;
                ended_next      = 1'b0;
            end
        end
    end

    // character stores and result payload
    always_ff @(posedge clk)
    begin
        mk_chars_reg   <= mk_chars_next;
        dg_chars_reg   <= dg_chars_next;
        bare_chars_reg <= bare_chars_next;
        out_reg        <= out_next;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg    <= ire_pkg::MIN_LENGTH_RST;
            max_len_reg    <= ire_pkg::MAX_LENGTH_RST;
            phase_reg      <= ire_pkg::PH_SEARCH;
            pos_reg        <= '0;
            mk_count_reg   <= '0;
            mk_valid_reg   <= 1'b0;
            dg_count_reg   <= '0;
            bare_valid_reg <= 1'b0;
            bare_count_reg <= '0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ire_pkg::CFG_MIN_LENGTH: min_len_reg <= cfg_data;
                    ire_pkg::CFG_MAX_LENGTH: max_len_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            mk_count_reg   <= mk_count_next;
            mk_valid_reg   <= mk_valid_next;
            dg_count_reg   <= dg_count_next;
            bare_valid_reg <= bare_valid_next;
            bare_count_reg <= bare_count_next;
            ended_reg      <= ended_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // marker verdict only exists once the field is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        mk_valid_reg |-> (phase_reg == ire_pkg::PH_DONE))
        else $error("marker valid outside done phase");

    // a kept bare run is never empty and always fits the store
    assert property (@(posedge clk) disable iff (!rst_n)
        bare_valid_reg |-> (bare_count_reg != '0) &&
                           (bare_count_reg <= CNT_W'(MAX_ID_CHARS)))
        else $error("bare run length out of range");

    // run counters saturate one past the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (mk_count_reg <= CNT_W'(SAT)) && (dg_count_reg <= CNT_W'(SAT)))
        else $error("run counter past saturation");

    // a final beat leaves clean response state and a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.final_req) |=> (phase_reg == ire_pkg::PH_SEARCH) && !ended_reg &&
                                      !mk_valid_reg && !bare_valid_reg && out_valid_reg)
        else $error("response state not cleared after final beat");

endmodule

// ----- src/iccid_response_extractor_core.sv -----
// Top level of the ICCID response extractor: byte classifier, queue and parser.
//
//  channel   dir   handshake             beat payload
//  in        in    in_valid/in_ready     in_data   (char_in, final_req)
//  out       out   out_valid/out_ready   out_data  (status, id_length, id_upper, id_lower)
//  cfg       in    cfg_we                cfg_index, cfg_data (min_length, max_length)
//
//  One byte per cycle sustained while no final byte waits; a byte is classified
//  on entry, held in the two-entry queue and parsed as it leaves the queue.
//  A final byte's result beat is presented from the edge at which it is parsed.
//  A final byte waits at the queue head while the result register holds a beat
//  not yet taken; bytes behind it wait too, and the input stalls once both
//  queue entries are full.
//  Reset clears all parse state and loads min_length 18, max_length 24.
module iccid_response_extractor_core
#(
    parameter int MAX_ID_CHARS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ire_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ire_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [ire_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ire_pkg::LEN_W-1:0]     cfg_data
);

    logic          q_valid;
    logic          q_pop;
    ire_pkg::cls_t q_item;

    // classify and queue
    ire_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // parse and report
    ire_back
    #(
        .MAX_ID_CHARS (MAX_ID_CHARS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
